// ===== src/fbp2r_pkg.sv =====
// Package for the framebuffer pixel converter: decode modes, payload struct and the 5-to-8 bit table.
`default_nettype none
package fbp2r_pkg;

    // Pixel size codes
    localparam logic [1:0] SIZE_8BPP  = 2'd1;
    localparam logic [1:0] SIZE_16BPP = 2'd2;
    localparam logic [1:0] SIZE_32BPP = 2'd3;

    // Pixel format codes
    localparam logic [2:0] FMT_RGBA = 3'd0;
    localparam logic [2:0] FMT_IA   = 3'd3;
    localparam logic [2:0] FMT_I    = 3'd4;

    // View codes
    localparam logic VIEW_COLOR    = 1'b0;
    localparam logic VIEW_COVERAGE = 1'b1;

    // Register indexes
    localparam logic [1:0] REG_SIZE   = 2'd0;
    localparam logic [1:0] REG_FORMAT = 2'd1;
    localparam logic [1:0] REG_VIEW   = 2'd2;

    // Reset values of the registers
    localparam logic [1:0] SIZE_RESET   = SIZE_16BPP;
    localparam logic [2:0] FORMAT_RESET = FMT_RGBA;
    localparam logic       VIEW_RESET   = VIEW_COLOR;

    localparam logic [31:0] FILL_WORD = 32'h3333_3333;
    localparam logic [7:0]  OPAQUE    = 8'hFF;

    // Decoded conversion for one pixel
    typedef enum logic [2:0] {
        MODE_RGBA32,
        MODE_RGBA16,
        MODE_IA16,
        MODE_I8,
        MODE_COV32,
        MODE_COV16,
        MODE_FILL
    } t_mode;

    // Per-channel bytes handed from the expand stage to the pack stage
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] grey;
        logic [7:0] grey_alpha;
    } t_chan;

    // Select the conversion from the register settings
    function automatic t_mode decode_mode(input logic [1:0] size, input logic [2:0] fmt,
                                          input logic view);
        t_mode m;
        m = MODE_FILL;
        if (view == VIEW_COVERAGE) begin
            case (size)
                SIZE_32BPP: m = MODE_COV32;
                SIZE_16BPP: m = MODE_COV16;
                default:    m = MODE_FILL;
            endcase
        end else begin
            case (size)
                SIZE_32BPP: m = (fmt == FMT_RGBA) ? MODE_RGBA32 : MODE_FILL;
                SIZE_16BPP: begin
                    if (fmt == FMT_RGBA)
                        m = MODE_RGBA16;
                    else if (fmt == FMT_IA)
                        m = MODE_IA16;
                    else
                        m = MODE_FILL;
                end
                SIZE_8BPP:  m = (fmt >= FMT_I) ? MODE_I8 : MODE_FILL;
                default:    m = MODE_FILL;
            endcase
        end
        return m;
    endfunction

    // Expand a 5-bit channel to 8 bits as x*255/31, truncating
    function automatic logic [7:0] expand5(input logic [4:0] x);
        logic [7:0] y;
        case (x)
            5'd0:  y = 8'd0;    5'd1:  y = 8'd8;    5'd2:  y = 8'd16;   5'd3:  y = 8'd24;
            5'd4:  y = 8'd32;   5'd5:  y = 8'd41;   5'd6:  y = 8'd49;   5'd7:  y = 8'd57;
            5'd8:  y = 8'd65;   5'd9:  y = 8'd74;   5'd10: y = 8'd82;   5'd11: y = 8'd90;
            5'd12: y = 8'd98;   5'd13: y = 8'd106;  5'd14: y = 8'd115;  5'd15: y = 8'd123;
            5'd16: y = 8'd131;  5'd17: y = 8'd139;  5'd18: y = 8'd148;  5'd19: y = 8'd156;
            5'd20: y = 8'd164;  5'd21: y = 8'd172;  5'd22: y = 8'd180;  5'd23: y = 8'd189;
            5'd24: y = 8'd197;  5'd25: y = 8'd205;  5'd26: y = 8'd213;  5'd27: y = 8'd222;
            5'd28: y = 8'd230;  5'd29: y = 8'd238;  5'd30: y = 8'd246;  5'd31: y = 8'd255;
            default: y = 8'd0;
        endcase
        return y;
    endfunction

endpackage
`default_nettype wire

// ===== src/framebuffer_pixel_to_rgba.sv =====
// Top level of the framebuffer pixel converter: three-stage pixel to RGBA8 pipeline.
//
// Usage:
//   Input channel: i_valid / o_stall carry one raw pixel word (i_pixel_word, right
//   aligned) and its end-of-frame mark. Output channel: o_valid / i_stall carry
//   one RGBA8 word (red 7:0, green 15:8, blue 23:16, alpha 31:24) and frame_last.
//   A word moves at a clock edge with valid high and stall low.
//   Each word passes the stages in order (decode, channel expand, pack), each a
//   register, and o_valid rises once it reaches the pack stage. One pixel is
//   taken every cycle while o_stall is low; each stage holds one word.
//   When the receiver stalls, the output stage holds its word and earlier
//   stages keep filling until the pipe is full, then o_stall rises; nothing is
//   lost or repeated.
//   Registers (size, format, view) are written through i_cfg_wr_en, index and
//   data; the user must write them only while the pipe is empty, as the block
//   does not enforce it. Index 3 is ignored. Synchronous active-low reset empties
//   the pipe and loads size 16bpp, format RGBA and the color view.
`default_nettype none
module framebuffer_pixel_to_rgba (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [2:0]  i_cfg_wr_data,
    // pixel input
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_pixel_word,
    input  wire logic        i_end_of_frame,
    // RGBA output
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_rgba_word,
    output logic             o_frame_last
);

    // Configuration registers
    logic [1:0] r_size;
    logic [2:0] r_format;
    logic       r_view;

    // Stage 1: decode
    logic              r_v1;
    fbp2r_pkg::t_mode  r_mode1;
    logic [31:0]       r_px1;
    logic              r_eof1;

    // Stage 2: channel bytes
    logic              r_v2;
    fbp2r_pkg::t_mode  r_mode2;
    logic [31:0]       r_px2;
    fbp2r_pkg::t_chan  r_chan2;
    logic              r_eof2;

    // Stage 3: output
    logic              r_v3;
    logic [31:0]       r_word3;
    logic              r_eof3;

    logic en1, en2, en3;
    fbp2r_pkg::t_chan n_chan2;
    logic [31:0]      n_word3;

    // Write the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size   <= fbp2r_pkg::SIZE_RESET;
            r_format <= fbp2r_pkg::FORMAT_RESET;
            r_view   <= fbp2r_pkg::VIEW_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                fbp2r_pkg::REG_SIZE:   r_size   <= i_cfg_wr_data[1:0];
                fbp2r_pkg::REG_FORMAT: r_format <= i_cfg_wr_data;
                fbp2r_pkg::REG_VIEW:   r_view   <= i_cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // Advance each stage when the stage after it can take its word
    assign en3     = !r_v3 || !i_stall;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;

    // Hold valid bits with their words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // Stage 1: latch the pixel and decode the conversion
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_mode1 <= fbp2r_pkg::decode_mode(r_size, r_format, r_view);
            r_px1   <= i_pixel_word;
            r_eof1  <= i_end_of_frame;
        end
    end

    // Stage 2: expand channels and form grey values
    always_comb begin
        n_chan2.red   = fbp2r_pkg::expand5(r_px1[15:11]);
        n_chan2.green = fbp2r_pkg::expand5(r_px1[10:6]);
        n_chan2.blue  = fbp2r_pkg::expand5(r_px1[5:1]);
        n_chan2.alpha = fbp2r_pkg::OPAQUE;
        n_chan2.grey_alpha = fbp2r_pkg::OPAQUE;
        case (r_mode1)
            fbp2r_pkg::MODE_IA16: begin
                n_chan2.grey       = r_px1[15:8];
                n_chan2.grey_alpha = r_px1[7:0];
            end
            fbp2r_pkg::MODE_I8:    n_chan2.grey = r_px1[7:0];
            fbp2r_pkg::MODE_COV32: n_chan2.grey = ~r_px1[7:0];
            fbp2r_pkg::MODE_COV16: n_chan2.grey = r_px1[0] ? 8'h00 : 8'hFF;
            default:               n_chan2.grey = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_mode2 <= r_mode1;
            r_px2   <= r_px1;
            r_chan2 <= n_chan2;
            r_eof2  <= r_eof1;
        end
    end

    // Stage 3: pack the output word
    always_comb begin
        case (r_mode2)
            fbp2r_pkg::MODE_RGBA32:
                n_word3 = {r_px2[7:0], r_px2[15:8], r_px2[23:16], r_px2[31:24]};
            fbp2r_pkg::MODE_RGBA16:
                n_word3 = {r_chan2.alpha, r_chan2.blue, r_chan2.green, r_chan2.red};
            fbp2r_pkg::MODE_IA16, fbp2r_pkg::MODE_I8,
            fbp2r_pkg::MODE_COV32, fbp2r_pkg::MODE_COV16:
                n_word3 = {r_chan2.grey_alpha, r_chan2.grey, r_chan2.grey, r_chan2.grey};
            default:
                n_word3 = fbp2r_pkg::FILL_WORD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_word3 <= n_word3;
            r_eof3  <= r_eof2;
        end
    end

    assign o_valid      = r_v3;
    assign o_rgba_word  = r_word3;
    assign o_frame_last = r_eof3;

endmodule
`default_nettype wire
